// ----- sv/iprm_pkg.sv -----
// Shared types and constants for the ICMP probe reply matcher.
// No dependencies; every other file in the block imports this package.
package iprm_pkg;

    localparam int POS_W                = 12;
    localparam int POS_CAP              = 4095;
    localparam int MAX_PACKET_BYTES_DEF = 2048;
    localparam int CFG_IDX_W            = 2;

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_IDENT = 2'd0,
        CFG_EXP_SEQ   = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_OTHER         = 2'd0,
        KIND_TIME_EXCEEDED = 2'd1,
        KIND_ECHO_REPLY    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic       matched;
        logic [1:0] reply_kind;
        logic       truncated;
    } t_out_word;

    typedef struct packed {
        logic [15:0] exp_ident;
        logic [15:0] exp_seq;
    } t_cfg;

endpackage

// ----- sv/iprm_in_stage.sv -----
// Input register stage of the reply matcher.
// Holds one received word until the parser takes it; uses iprm_pkg.
module iprm_in_stage
    import iprm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    input  logic     i_take,
    output logic     o_stall,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    // Stall only while a held word is not being taken this cycle.
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// ----- sv/iprm_parser.sv -----
// Per-packet header walk and echo field compare for the reply matcher.
// Keeps the packet state and forms the result on the last byte; uses iprm_pkg.
module iprm_parser
    import iprm_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    input  logic      i_out_free,
    output logic      o_take,
    output logic      o_res_valid,
    output t_out_word o_res
);

    localparam logic [POS_W-1:0] POS_LIMIT =
        POS_W'((MAX_PACKET_BYTES > POS_CAP) ? POS_CAP : MAX_PACKET_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [5:0]       r_hlen, n_hlen;
    logic [7:0]       r_type, n_type;
    logic [5:0]       r_ilen, n_ilen;
    logic [3:0]       r_cnt, n_cnt;
    logic [3:0]       r_eq, n_eq;

    logic             active, beyond_hdr;
    logic [7:0]       h8;
    logic [POS_W-1:0] e_base, t_base, e_diff, t_diff, inner_at;
    logic             e_hit, t_hit, hit;
    logic [1:0]       k;
    logic             type_seen, done;
    t_kind            kind;

    function automatic logic [7:0] want_byte(logic [1:0] idx, t_cfg c);
        logic [7:0] w;
        case (idx)
            2'd0:    w = c.exp_ident[15:8];
            2'd1:    w = c.exp_ident[7:0];
            2'd2:    w = c.exp_seq[15:8];
            default: w = c.exp_seq[7:0];
        endcase
        return w;
    endfunction

    // A word without the last mark gives no result and can always advance.
    assign o_take = i_valid && (!i_word.last_byte || i_out_free);

    always_comb begin
        active = r_pos < POS_LIMIT;
        n_hlen = (active && r_pos == '0) ? {i_word.data_byte[3:0], 2'b00} : r_hlen;
        n_type = (active && r_pos == POS_W'(n_hlen)) ? i_word.data_byte : r_type;
        beyond_hdr = active && (r_pos > POS_W'(n_hlen));
        h8 = {2'b00, n_hlen};

        // Echo reply: identifier and sequence follow the 4-byte ICMP head.
        e_base = POS_W'(h8 + 8'd4);
        e_diff = r_pos - e_base;
        e_hit  = beyond_hdr && (r_type == TYPE_ECHO_REPLY) &&
                 (r_pos >= e_base) && (e_diff < POS_W'(4));

        // Time exceeded: quoted header starts 8 bytes past the outer one.
        inner_at = POS_W'(h8 + 8'd8);
        t_base   = POS_W'(h8 + 8'd12 + {2'b00, r_ilen});
        t_diff   = r_pos - t_base;
        t_hit    = beyond_hdr && (r_type == TYPE_TIME_EXCEEDED) &&
                   (r_pos >= t_base) && (t_diff < POS_W'(4));
        n_ilen   = (beyond_hdr && (r_type == TYPE_TIME_EXCEEDED) && r_pos == inner_at) ?
                   {i_word.data_byte[3:0], 2'b00} : r_ilen;

        hit   = e_hit || t_hit;
        k     = e_hit ? e_diff[1:0] : t_diff[1:0];
        n_cnt = r_cnt + {3'b000, hit};
        n_eq  = r_eq + {3'b000, hit && (i_word.data_byte == want_byte(k, i_cfg))};
        n_pos = active ? r_pos + POS_W'(1) : r_pos;

        type_seen = n_pos > POS_W'(n_hlen);
        done      = n_cnt == 4'd4;
        kind      = KIND_OTHER;
        if (type_seen && n_type == TYPE_TIME_EXCEEDED) begin
            kind = KIND_TIME_EXCEEDED;
        end else if (type_seen && n_type == TYPE_ECHO_REPLY) begin
            kind = KIND_ECHO_REPLY;
        end
        o_res.reply_kind = kind;
        o_res.truncated  = !type_seen || ((kind != KIND_OTHER) && !done);
        o_res.matched    = (kind != KIND_OTHER) && done && (n_eq == 4'd4);
    end

    assign o_res_valid = o_take && i_word.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hlen <= '0;
            r_type <= '0;
            r_ilen <= '0;
            r_cnt  <= '0;
            r_eq   <= '0;
        end else if (o_take) begin
            if (i_word.last_byte) begin
                // Drop all packet state for the next packet.
                r_pos  <= '0;
                r_hlen <= '0;
                r_type <= '0;
                r_ilen <= '0;
                r_cnt  <= '0;
                r_eq   <= '0;
            end else begin
                r_pos  <= n_pos;
                r_hlen <= n_hlen;
                r_type <= n_type;
                r_ilen <= n_ilen;
                r_cnt  <= n_cnt;
                r_eq   <= n_eq;
            end
        end
    end

endmodule

// ----- sv/iprm_out_reg.sv -----
// Result register of the reply matcher.
// Holds one result until the receiver takes it; uses iprm_pkg.
module iprm_out_reg
    import iprm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_res,
    input  logic      i_stall,
    output logic      o_free,
    output logic      o_valid,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_word <= i_res;
        end
    end

endmodule

// ----- sv/icmp_probe_reply_matcher.sv -----
// ICMP probe reply matcher: one packet byte per cycle, one result per packet.
// A last byte goes through the input register, then the result register.
// Throughput: one byte every cycle, set by the single input register to result
// register pass; back-pressure on the result side stalls only a last byte.
// Reset (synchronous, active low) clears packet state, both register valid flags,
// and expected identifier and sequence to zero. Uses iprm_pkg and submodules.
module icmp_probe_reply_matcher
    import iprm_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg      r_cfg;
    logic      w_s1_valid;
    t_in_word  w_s1_word;
    logic      w_take;
    logic      w_out_free;
    logic      w_res_valid;
    t_out_word w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EXP_IDENT: r_cfg.exp_ident <= i_cfg_data;
                CFG_EXP_SEQ:   r_cfg.exp_seq   <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    iprm_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_take  (w_take),
        .o_stall (o_in_stall),
        .o_valid (w_s1_valid),
        .o_word  (w_s1_word)
    );

    iprm_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_s1_valid),
        .i_word      (w_s1_word),
        .i_cfg       (r_cfg),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    iprm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    a_match_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.matched |->
            !o_out_word.truncated && (o_out_word.reply_kind != KIND_OTHER))
        else $error("match reported on truncated or unrelated packet");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_s1_valid && w_s1_word.last_byte)
        else $error("input stalled without a held last byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !w_res_valid)
        else $error("result issued into an occupied output register");

    a_result_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> o_out_valid)
        else $error("issued result did not reach the output register");

endmodule
